[design/bgpm_pkg.sv]
// Shared constants, register codes and queue entry type for the box ghost mirror.
// No dependencies; imported by the top level and its port checker.
package bgpm_pkg;

   // field widths
   localparam int COORD_BITS     = 32;
   localparam int LEN_BITS       = 31;
   localparam int ID_BITS        = 20;
   localparam int FRAC_BITS      = 16;

   // factor * h, full and after dropping the fraction
   localparam int PROD_FULL_BITS = 2 * LEN_BITS;
   localparam int PROD_BITS      = PROD_FULL_BITS - FRAC_BITS;
   // a kept offset lies below eta*h, so it fits the product width
   localparam int OFF_BITS       = PROD_BITS;
   localparam int DIST_BITS      = (COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS;
   localparam int SUM_BITS       = ((COORD_BITS > OFF_BITS + 1) ? COORD_BITS : OFF_BITS + 1) + 2;

   localparam int NUM_AXES       = 3;
   localparam int NUM_CANDS      = 3;
   localparam int NUM_COMBOS     = NUM_CANDS * NUM_CANDS * NUM_CANDS;

   // ghost source queue
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

   // register port
   localparam int CSR_DATA_BITS  = (COORD_BITS > 32) ? 64 : 32;
   localparam int CSR_LSB_BITS   = (CSR_DATA_BITS == 64) ? 3 : 2;
   localparam int REG_IDX_BITS   = 3;
   localparam int CSR_ADDR_BITS  = CSR_LSB_BITS + REG_IDX_BITS;

   localparam logic [COORD_BITS-1:0] BOX_LOW_RESET  = '0;
   localparam logic [COORD_BITS-1:0] BOX_HIGH_RESET = COORD_BITS'(65536);
   localparam logic [LEN_BITS-1:0]   REACH_RESET    = LEN_BITS'(131072);
   localparam logic [LEN_BITS-1:0]   GAP_RESET      = LEN_BITS'(3277);

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_BOX_LOW_X      = 3'd0,
      REG_BOX_LOW_Y      = 3'd1,
      REG_BOX_LOW_Z      = 3'd2,
      REG_BOX_HIGH_X     = 3'd3,
      REG_BOX_HIGH_Y     = 3'd4,
      REG_BOX_HIGH_Z     = 3'd5,
      REG_REACH_FACTOR   = 3'd6,
      REG_MIN_GAP_FACTOR = 3'd7
   } csr_reg_type;

   // per-axis candidate: mirror across lower face, stay, mirror across upper face
   typedef enum logic [1:0] {
      CAND_MINUS = 2'd0,
      CAND_ZERO  = 2'd1,
      CAND_PLUS  = 2'd2
   } cand_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_BITS-1:0] pos;
      logic [NUM_AXES-1:0][OFF_BITS-1:0]   off_lo;
      logic [NUM_AXES-1:0][OFF_BITS-1:0]   off_hi;
      logic [LEN_BITS-1:0]                 len;
      logic [ID_BITS-1:0]                  id;
   } ghost_src_type;

endpackage

[design/box_ghost_particle_mirror.sv]
// Box ghost-particle mirror: box test, per-axis mirror offsets, ghost queue and emitter.
// Depends on bgpm_pkg.
//
//   channel   direction  handshake                         payload
//   request   in         start & !busy at the clock edge   req_pos_x/y/z, req_smoothing_len,
//                                                          req_particle_id
//   response  out        rsp_valid, one cycle per ghost    rsp_ghost_x/y/z, rsp_ghost_len,
//                                                          rsp_source_id, rsp_last_ghost
//   registers in/out     psel & penable & pwrite & pready  paddr, pwdata, prdata
//
// A particle is taken every cycle while busy is low; particles that make no ghost leave
// no trace. A particle with ghosts is queued and then emits one ghost per cycle, 1 to 26
// ghosts in all; with an empty queue the first ghost passes the input register, the
// product stage, the queue, the emitter and the result register. busy rises when the
// eight-entry ghost queue plus the two particles still in the front stages could fill
// it. Reset is synchronous; the receiver cannot stall, so the response side never holds.
module box_ghost_particle_mirror (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [bgpm_pkg::COORD_BITS-1:0]  req_pos_x,
   input  logic signed [bgpm_pkg::COORD_BITS-1:0]  req_pos_y,
   input  logic signed [bgpm_pkg::COORD_BITS-1:0]  req_pos_z,
   input  logic [bgpm_pkg::LEN_BITS-1:0]           req_smoothing_len,
   input  logic [bgpm_pkg::ID_BITS-1:0]            req_particle_id,
   output logic                                    rsp_valid,
   output logic signed [bgpm_pkg::COORD_BITS-1:0]  rsp_ghost_x,
   output logic signed [bgpm_pkg::COORD_BITS-1:0]  rsp_ghost_y,
   output logic signed [bgpm_pkg::COORD_BITS-1:0]  rsp_ghost_z,
   output logic [bgpm_pkg::LEN_BITS-1:0]           rsp_ghost_len,
   output logic [bgpm_pkg::ID_BITS-1:0]            rsp_source_id,
   output logic                                    rsp_last_ghost,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [bgpm_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [bgpm_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [bgpm_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                    pready
);
   import bgpm_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [NUM_AXES-1:0][COORD_BITS-1:0] box_lo_ff, box_lo_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] box_hi_ff, box_hi_in;
   logic [LEN_BITS-1:0]                 reach_ff, reach_in;
   logic [LEN_BITS-1:0]                 gap_ff, gap_in;
   logic                                csr_wr;
   csr_reg_type                         csr_idx;

   // ---------------------------------------------------------------- stage 1: input register
   logic                                accept;
   logic                                s1_valid_ff, s1_valid_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] s1_pos_ff, s1_pos_in;
   logic [LEN_BITS-1:0]                 s1_len_ff;
   logic [ID_BITS-1:0]                  s1_id_ff;
   logic [NUM_AXES-1:0]                 s1_inside;
   logic [NUM_AXES-1:0][COORD_BITS:0]   s1_dlo_wide, s1_dhi_wide;
   logic [PROD_FULL_BITS-1:0]           s1_eps_prod, s1_eta_prod;

   // ---------------------------------------------------------------- stage 2: products, distances
   logic                                s2_valid_ff, s2_valid_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] s2_pos_ff;
   logic [LEN_BITS-1:0]                 s2_len_ff;
   logic [ID_BITS-1:0]                  s2_id_ff;
   logic [PROD_BITS-1:0]                s2_eps_ff, s2_eps_in;
   logic [PROD_BITS-1:0]                s2_eta_ff, s2_eta_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] s2_dlo_ff, s2_dlo_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] s2_dhi_ff, s2_dhi_in;
   logic [NUM_AXES-1:0][DIST_BITS-1:0]  s2_dcl_lo, s2_dcl_hi;
   logic [NUM_AXES-1:0][NUM_CANDS-1:0]  s2_keep, s2_zero;
   logic [NUM_COMBOS-1:0]               s2_mask;
   ghost_src_type                       s2_src;
   logic                                push;

   // ---------------------------------------------------------------- ghost source queue
   ghost_src_type                       fifo_src_mem  [FIFO_DEPTH];
   logic [NUM_COMBOS-1:0]               fifo_mask_mem [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]            count_ff, count_in;
   logic [FIFO_CNT_BITS:0]              load_sum;
   logic                                fifo_pop;

   // ---------------------------------------------------------------- emitter
   logic                                em_valid_ff, em_valid_in;
   ghost_src_type                       em_src_ff;
   logic [NUM_COMBOS-1:0]               em_mask_ff, em_rest;
   logic                                em_last;
   cand_type                            em_sel [NUM_AXES];
   logic [NUM_AXES-1:0][COORD_BITS-1:0] em_ghost;

   // ---------------------------------------------------------------- result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic [NUM_AXES-1:0][COORD_BITS-1:0] rsp_ghost_ff;
   logic [LEN_BITS-1:0]                 rsp_len_ff;
   logic [ID_BITS-1:0]                  rsp_id_ff;

   // Clamp an exact ghost coordinate to the signed coordinate range.
   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [SUM_BITS-1:0] v);
      logic [SUM_BITS-COORD_BITS:0] top;
      logic [COORD_BITS-1:0]        r;
      top = v[SUM_BITS-1:COORD_BITS-1];
      if (&top || ~|top) begin
         r = v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // ================================================================ register port
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = csr_reg_type'(paddr[CSR_ADDR_BITS-1:CSR_LSB_BITS]);
   assign pready  = 1'b1;

   always_comb begin
      box_lo_in = box_lo_ff;
      box_hi_in = box_hi_ff;
      reach_in  = reach_ff;
      gap_in    = gap_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_BOX_LOW_X:      box_lo_in[0] = pwdata[COORD_BITS-1:0];
            REG_BOX_LOW_Y:      box_lo_in[1] = pwdata[COORD_BITS-1:0];
            REG_BOX_LOW_Z:      box_lo_in[2] = pwdata[COORD_BITS-1:0];
            REG_BOX_HIGH_X:     box_hi_in[0] = pwdata[COORD_BITS-1:0];
            REG_BOX_HIGH_Y:     box_hi_in[1] = pwdata[COORD_BITS-1:0];
            REG_BOX_HIGH_Z:     box_hi_in[2] = pwdata[COORD_BITS-1:0];
            REG_REACH_FACTOR:   reach_in     = pwdata[LEN_BITS-1:0];
            REG_MIN_GAP_FACTOR: gap_in       = pwdata[LEN_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_lo_ff <= {NUM_AXES{BOX_LOW_RESET}};
         box_hi_ff <= {NUM_AXES{BOX_HIGH_RESET}};
         reach_ff  <= REACH_RESET;
         gap_ff    <= GAP_RESET;
      end else begin
         box_lo_ff <= box_lo_in;
         box_hi_ff <= box_hi_in;
         reach_ff  <= reach_in;
         gap_ff    <= gap_in;
      end
   end

   // read back raw register bits, zero-extended
   always_comb begin
      unique case (csr_idx)
         REG_BOX_LOW_X:      prdata = CSR_DATA_BITS'(box_lo_ff[0]);
         REG_BOX_LOW_Y:      prdata = CSR_DATA_BITS'(box_lo_ff[1]);
         REG_BOX_LOW_Z:      prdata = CSR_DATA_BITS'(box_lo_ff[2]);
         REG_BOX_HIGH_X:     prdata = CSR_DATA_BITS'(box_hi_ff[0]);
         REG_BOX_HIGH_Y:     prdata = CSR_DATA_BITS'(box_hi_ff[1]);
         REG_BOX_HIGH_Z:     prdata = CSR_DATA_BITS'(box_hi_ff[2]);
         REG_REACH_FACTOR:   prdata = CSR_DATA_BITS'(reach_ff);
         REG_MIN_GAP_FACTOR: prdata = CSR_DATA_BITS'(gap_ff);
      endcase
   end

   // ================================================================ stage 1
   // Take a particle whenever the queue can still absorb everything in flight.
   assign accept      = start & ~busy;
   assign s1_valid_in = accept;
   assign s1_pos_in   = {req_pos_z, req_pos_y, req_pos_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
      s1_len_ff <= req_smoothing_len;
      s1_id_ff  <= req_particle_id;
   end

   // Inclusive box test and exact face distances; an inverted box contains nothing.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_inside[a]   = ($signed(s1_pos_ff[a]) >= $signed(box_lo_ff[a])) &&
                          ($signed(s1_pos_ff[a]) <= $signed(box_hi_ff[a]));
         s1_dlo_wide[a] = {s1_pos_ff[a][COORD_BITS-1], s1_pos_ff[a]} -
                          {box_lo_ff[a][COORD_BITS-1], box_lo_ff[a]};
         s1_dhi_wide[a] = {box_hi_ff[a][COORD_BITS-1], box_hi_ff[a]} -
                          {s1_pos_ff[a][COORD_BITS-1], s1_pos_ff[a]};
      end
   end

   // eps*h and eta*h, one multiplier each, fraction dropped
   assign s1_eps_prod = PROD_FULL_BITS'(gap_ff) * PROD_FULL_BITS'(s1_len_ff);
   assign s1_eta_prod = PROD_FULL_BITS'(reach_ff) * PROD_FULL_BITS'(s1_len_ff);

   assign s2_valid_in = s1_valid_ff & (&s1_inside);
   assign s2_eps_in   = s1_eps_prod[PROD_FULL_BITS-1:FRAC_BITS];
   assign s2_eta_in   = s1_eta_prod[PROD_FULL_BITS-1:FRAC_BITS];

   // inside the box both distances are non-negative and fit the coordinate width
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s2_dlo_in[a] = s1_dlo_wide[a][COORD_BITS-1:0];
         s2_dhi_in[a] = s1_dhi_wide[a][COORD_BITS-1:0];
      end
   end

   // ================================================================ stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_pos_ff <= s1_pos_ff;
      s2_len_ff <= s1_len_ff;
      s2_id_ff  <= s1_id_ff;
      s2_eps_ff <= s2_eps_in;
      s2_eta_ff <= s2_eta_in;
      s2_dlo_ff <= s2_dlo_in;
      s2_dhi_ff <= s2_dhi_in;
   end

   // Floor distances at eps*h, keep candidates strictly inside eta*h.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s2_dcl_lo[a] = (DIST_BITS'(s2_dlo_ff[a]) < DIST_BITS'(s2_eps_ff)) ?
                        DIST_BITS'(s2_eps_ff) : DIST_BITS'(s2_dlo_ff[a]);
         s2_dcl_hi[a] = (DIST_BITS'(s2_dhi_ff[a]) < DIST_BITS'(s2_eps_ff)) ?
                        DIST_BITS'(s2_eps_ff) : DIST_BITS'(s2_dhi_ff[a]);
         s2_keep[a][CAND_MINUS] = s2_dcl_lo[a] < DIST_BITS'(s2_eta_ff);
         s2_keep[a][CAND_ZERO]  = s2_eta_ff != '0;
         s2_keep[a][CAND_PLUS]  = s2_dcl_hi[a] < DIST_BITS'(s2_eta_ff);
         s2_zero[a][CAND_MINUS] = s2_dcl_lo[a] == '0;
         s2_zero[a][CAND_ZERO]  = 1'b1;
         s2_zero[a][CAND_PLUS]  = s2_dcl_hi[a] == '0;
      end
   end

   // One bit per combination, x outermost; drop the combination with no net offset.
   always_comb begin
      for (int ix = 0; ix < NUM_CANDS; ix++) begin
         for (int iy = 0; iy < NUM_CANDS; iy++) begin
            for (int iz = 0; iz < NUM_CANDS; iz++) begin
               s2_mask[(ix * NUM_CANDS + iy) * NUM_CANDS + iz] =
                  s2_keep[0][ix] & s2_keep[1][iy] & s2_keep[2][iz] &
                  ~(s2_zero[0][ix] & s2_zero[1][iy] & s2_zero[2][iz]);
            end
         end
      end
   end

   // kept offsets lie below eta*h, and the offset field is as wide as the distance, so it loses nothing
   always_comb begin
      s2_src.pos = s2_pos_ff;
      s2_src.len = s2_len_ff;
      s2_src.id  = s2_id_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         s2_src.off_lo[a] = s2_dcl_lo[a][OFF_BITS-1:0];
         s2_src.off_hi[a] = s2_dcl_hi[a][OFF_BITS-1:0];
      end
   end

   assign push = s2_valid_ff & (|s2_mask);

   // ================================================================ ghost source queue
   assign fifo_pop  = (count_ff != '0) & (~em_valid_ff | em_last);
   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 :
                      wr_ptr_ff + FIFO_PTR_BITS'(1);
   assign rd_ptr_in = !fifo_pop ? rd_ptr_ff :
                      (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 :
                      rd_ptr_ff + FIFO_PTR_BITS'(1);
   assign count_in  = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(fifo_pop);

   // Hold off new particles while queue plus front stages could overflow the queue.
   assign load_sum  = (FIFO_CNT_BITS+1)'(count_ff) + (FIFO_CNT_BITS+1)'(s1_valid_ff) +
                      (FIFO_CNT_BITS+1)'(s2_valid_ff);
   assign busy      = load_sum >= (FIFO_CNT_BITS+1)'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_src_mem[wr_ptr_ff]  <= s2_src;
         fifo_mask_mem[wr_ptr_ff] <= s2_mask;
      end
   end

   // ================================================================ emitter
   // Lowest set bit is the next combination in order; clear it once emitted.
   assign em_rest     = em_mask_ff & (em_mask_ff - NUM_COMBOS'(1));
   assign em_last     = em_rest == '0;
   assign em_valid_in = fifo_pop | (em_valid_ff & ~em_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
      end else begin
         em_valid_ff <= em_valid_in;
      end
   end

   // registered queue read; advance the running mask otherwise
   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         em_src_ff  <= fifo_src_mem[rd_ptr_ff];
         em_mask_ff <= fifo_mask_mem[rd_ptr_ff];
      end else begin
         em_mask_ff <= em_rest;
      end
   end

   // priority pick: scan from the last combination down so the first set bit wins
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         em_sel[a] = CAND_MINUS;
      end
      for (int ix = NUM_CANDS - 1; ix >= 0; ix--) begin
         for (int iy = NUM_CANDS - 1; iy >= 0; iy--) begin
            for (int iz = NUM_CANDS - 1; iz >= 0; iz--) begin
               if (em_mask_ff[(ix * NUM_CANDS + iy) * NUM_CANDS + iz]) begin
                  em_sel[0] = cand_type'(2'(ix));
                  em_sel[1] = cand_type'(2'(iy));
                  em_sel[2] = cand_type'(2'(iz));
               end
            end
         end
      end
   end

   // ghost = position - 2*off_lo, position + 2*off_hi or position itself, exact, then clamped
   always_comb begin
      logic [SUM_BITS-1:0] p_ext;
      logic [SUM_BITS-1:0] twice_lo;
      logic [SUM_BITS-1:0] twice_hi;
      logic [SUM_BITS-1:0] sum;
      for (int a = 0; a < NUM_AXES; a++) begin
         p_ext    = SUM_BITS'($signed(em_src_ff.pos[a]));
         twice_lo = {{(SUM_BITS-OFF_BITS-1){1'b0}}, em_src_ff.off_lo[a], 1'b0};
         twice_hi = {{(SUM_BITS-OFF_BITS-1){1'b0}}, em_src_ff.off_hi[a], 1'b0};
         case (em_sel[a])
            CAND_MINUS: sum = p_ext - twice_lo;
            CAND_PLUS:  sum = p_ext + twice_hi;
            default:    sum = p_ext;
         endcase
         em_ghost[a] = sat_coord(sum);
      end
   end

   // ================================================================ result register
   assign rsp_valid_in = em_valid_ff;
   assign rsp_last_in  = em_valid_ff & em_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ghost_ff <= em_ghost;
      rsp_len_ff   <= em_src_ff.len;
      rsp_id_ff    <= em_src_ff.id;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ghost_x    = rsp_ghost_ff[0];
   assign rsp_ghost_y    = rsp_ghost_ff[1];
   assign rsp_ghost_z    = rsp_ghost_ff[2];
   assign rsp_ghost_len  = rsp_len_ff;
   assign rsp_source_id  = rsp_id_ff;
   assign rsp_last_ghost = rsp_last_ff;

endmodule

[design/bgpm_checker.sv]
// Port-level checks for the box ghost mirror, bound to the top level.
// Depends on bgpm_pkg and box_ghost_particle_mirror.
module bgpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [bgpm_pkg::LEN_BITS-1:0] rsp_ghost_len,
   input logic [bgpm_pkg::ID_BITS-1:0]  rsp_source_id,
   input logic                          rsp_last_ghost
);
   import bgpm_pkg::*;

   // reset drops the output strobe and frees the request side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("output strobe or busy not clear after reset");

   // the last-ghost mark only rides on a transfer
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_ghost |-> rsp_valid)
      else $error("last ghost flagged without a transfer");

   // a burst runs without gaps and keeps its source particle
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_ghost |=>
         rsp_valid && rsp_source_id == $past(rsp_source_id) &&
         rsp_ghost_len == $past(rsp_ghost_len))
      else $error("ghost burst broken before its last ghost");

   // zero smoothing length leaves zero reach, so no ghost can carry it
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ghost_len != '0)
      else $error("ghost emitted for zero smoothing length");

endmodule

bind box_ghost_particle_mirror bgpm_checker u_bgpm_checker (.*);
